>>> rtl/core/urbx_pkg.sv
`timescale 1ns / 1ps

package urbx_pkg;

  localparam int RING_DEPTH_DEF = 512;

  localparam int BYTE_W    = 8;
  localparam int REQ_W     = 2;
  localparam int FILL_W    = 9;
  localparam int LEVEL_W   = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 9;
  localparam int M_TDATA_W = 32;

  // event codes carried on s_tuser
  localparam logic [REQ_W-1:0] REQ_LINE_RX  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TX_READY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_HOST_WR  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_HOST_RD  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XOFF_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_XON_LEVEL   = 2'd2;

  localparam logic               FLOW_ENABLE_RST = 1'b1;
  localparam logic [LEVEL_W-1:0] XOFF_LEVEL_RST  = 9'd384;
  localparam logic [LEVEL_W-1:0] XON_LEVEL_RST   = 9'd256;

  localparam logic [BYTE_W-1:0] XON_CHAR  = 8'd17;
  localparam logic [BYTE_W-1:0] XOFF_CHAR = 8'd19;

  typedef struct packed {
    logic rx_line;   // line byte event
    logic tx_ready;  // transmitter asks for a byte
    logic tx_empty;  // transmit ring empty
    logic tx_start;  // host byte went into an empty transmit ring
  } ctrl_evt_t;

  typedef struct packed {
    logic              send_flow;
    logic [BYTE_W-1:0] flow_byte;
    logic              tx_get;
    logic              tx_busy;
  } ctrl_act_t;

endpackage

>>> rtl/core/urbx_ring.sv
`timescale 1ns / 1ps

module urbx_ring
  import urbx_pkg::*;
#(
  parameter int DEPTH = RING_DEPTH_DEF,
  parameter int PTR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              put,
  input  logic              get,
  input  logic [BYTE_W-1:0] wdata,
  output logic [BYTE_W-1:0] rdata,
  output logic [PTR_W-1:0]  fill,
  output logic              full,
  output logic              empty
);

  localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(DEPTH);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  head_next;
  logic [PTR_W-1:0]  tail_next;

  assign head_next = (head == LAST) ? '0 : head + 1'b1;
  assign tail_next = (tail == LAST) ? '0 : tail + 1'b1;

  assign full  = (head_next == tail);
  assign empty = (head == tail);
  // wraps modulo 2^PTR_W when the depth is a power of two
  assign fill  = (head >= tail) ? head - tail : head + DEPTH_P - tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (put) head <= head_next;
      if (get) tail <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (put) mem[head] <= wdata;
    if (get) rdata <= mem[tail];
  end

endmodule

>>> rtl/core/urbx_ctrl.sv
`timescale 1ns / 1ps

module urbx_ctrl
  import urbx_pkg::*;
#(
  parameter int FILL_EXT_W = FILL_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  step,
  input  ctrl_evt_t             evt,
  input  logic [FILL_EXT_W-1:0] flow_fill,
  output ctrl_act_t             act
);

  logic               flow_enable;
  logic [LEVEL_W-1:0] xoff_level;
  logic [LEVEL_W-1:0] xon_level;

  logic xon_state, xon_state_next;
  logic xoff_state, xoff_state_next;
  logic flow_pending, flow_pending_next;
  logic tx_enable, tx_enable_next;

  always_comb begin
    xon_state_next    = xon_state;
    xoff_state_next   = xoff_state;
    flow_pending_next = flow_pending;
    tx_enable_next    = tx_enable;
    act               = '0;

    if (evt.rx_line && flow_enable) begin
      // xoff test wins when the levels cross
      if (flow_fill >= FILL_EXT_W'(xoff_level)) begin
        xon_state_next = 1'b0;
        if (!xoff_state) begin
          xoff_state_next   = 1'b1;
          flow_pending_next = 1'b1;
          tx_enable_next    = 1'b1;
        end
      end else if (flow_fill <= FILL_EXT_W'(xon_level)) begin
        xoff_state_next = 1'b0;
        if (!xon_state) begin
          xon_state_next    = 1'b1;
          flow_pending_next = 1'b1;
          tx_enable_next    = 1'b1;
        end
      end
    end

    if (evt.tx_ready && tx_enable) begin
      if (flow_pending) begin
        act.send_flow     = 1'b1;
        act.flow_byte     = xon_state ? XON_CHAR : (xoff_state ? XOFF_CHAR : '0);
        flow_pending_next = 1'b0;
      end else if (evt.tx_empty) begin
        tx_enable_next = 1'b0;
      end else begin
        act.tx_get = 1'b1;
      end
    end

    if (evt.tx_start) tx_enable_next = 1'b1;

    act.tx_busy = tx_enable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xon_state    <= 1'b1;
      xoff_state   <= 1'b0;
      flow_pending <= 1'b0;
      tx_enable    <= 1'b0;
    end else if (step) begin
      xon_state    <= xon_state_next;
      xoff_state   <= xoff_state_next;
      flow_pending <= flow_pending_next;
      tx_enable    <= tx_enable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_enable <= FLOW_ENABLE_RST;
      xoff_level  <= XOFF_LEVEL_RST;
      xon_level   <= XON_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLOW_ENABLE: flow_enable <= cfg_data[0];
        CFG_XOFF_LEVEL:  xoff_level  <= cfg_data[LEVEL_W-1:0];
        CFG_XON_LEVEL:   xon_level   <= cfg_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/uart_ring_buffers_xon_xoff_core.sv
`timescale 1ns / 1ps

// channel  port group          payload
// in       s_tvalid/s_tready   s_tuser: req_type; s_tdata: data_byte
// out      m_tvalid/m_tready   m_tdata: line_valid, line_byte, host_valid, host_byte,
//                              fill_count, accepted, tx_busy
// config   cfg_we              cfg_index selects the register, cfg_data holds the value
//
// one event per cycle while m_tready does not hold the result; a word passes the input
// register, then the result register, loaded together with the registered ring memory read
// reset clears ring pointers, flow state and the registers to their defaults
// the rings hold data only once written, so no clearing pass follows reset
// with m_tready low the result holds; s_tready falls once both stages are full
// and m_tready is low

module uart_ring_buffers_xon_xoff_core
  import urbx_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // data_byte
  input  logic [REQ_W-1:0]     s_tuser,   // req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // line_valid, line_byte, host_valid, host_byte, fill_count, accepted, tx_busy, zero pad
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int EXT_W = (PTR_W > FILL_W) ? PTR_W : FILL_W;
  localparam logic [EXT_W-1:0] FULL_FILL = EXT_W'(RING_DEPTH - 1);

  // input stage
  logic              in_vld;
  logic [REQ_W-1:0]  in_req;
  logic [BYTE_W-1:0] in_byte;
  logic              adv;

  assign adv      = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req  <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  // event decode
  logic is_rx, is_txr, is_wr, is_rd;

  always_comb begin
    is_rx  = 1'b0;
    is_txr = 1'b0;
    is_wr  = 1'b0;
    is_rd  = 1'b0;
    unique case (in_req)
      REQ_LINE_RX:  is_rx  = adv;
      REQ_TX_READY: is_txr = adv;
      REQ_HOST_WR:  is_wr  = adv;
      REQ_HOST_RD:  is_rd  = adv;
      default: begin
      end
    endcase
  end

  logic              rx_put, rx_get, rx_full, rx_empty;
  logic              tx_put, tx_full, tx_empty;
  logic [PTR_W-1:0]  rx_fill, tx_fill;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;
  logic [EXT_W-1:0]  rx_fill_ext, tx_fill_ext;
  logic [EXT_W-1:0]  flow_fill;
  logic [EXT_W-1:0]  fill_sel;
  ctrl_evt_t         evt;
  ctrl_act_t         act;

  assign rx_put = is_rx && !rx_full;
  assign rx_get = is_rd && !rx_empty;
  assign tx_put = is_wr && !tx_full;

  assign rx_fill_ext = EXT_W'(rx_fill);
  assign tx_fill_ext = EXT_W'(tx_fill);

  // a dropped byte still counts as a full ring for flow control
  assign flow_fill = rx_full ? FULL_FILL : rx_fill_ext + 1'b1;

  assign evt.rx_line  = is_rx;
  assign evt.tx_ready = is_txr;
  assign evt.tx_empty = tx_empty;
  assign evt.tx_start = tx_put && (tx_fill == '0);

  always_comb begin
    fill_sel = '0;
    unique case (in_req)
      REQ_LINE_RX:  fill_sel = rx_full ? '0 : rx_fill_ext + 1'b1;
      REQ_TX_READY: fill_sel = tx_fill_ext;
      REQ_HOST_WR:  fill_sel = tx_full ? '0 : tx_fill_ext + 1'b1;
      REQ_HOST_RD:  fill_sel = rx_fill_ext;
      default:      fill_sel = '0;
    endcase
  end

  urbx_ring #(
    .DEPTH (RING_DEPTH),
    .PTR_W (PTR_W)
  ) u_rx_ring (
    .clk   (clk),
    .rst   (rst),
    .put   (rx_put),
    .get   (rx_get),
    .wdata (in_byte),
    .rdata (rx_rdata),
    .fill  (rx_fill),
    .full  (rx_full),
    .empty (rx_empty)
  );

  urbx_ring #(
    .DEPTH (RING_DEPTH),
    .PTR_W (PTR_W)
  ) u_tx_ring (
    .clk   (clk),
    .rst   (rst),
    .put   (tx_put),
    .get   (act.tx_get),
    .wdata (in_byte),
    .rdata (tx_rdata),
    .fill  (tx_fill),
    .full  (tx_full),
    .empty (tx_empty)
  );

  urbx_ctrl #(
    .FILL_EXT_W (EXT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (adv),
    .evt       (evt),
    .flow_fill (flow_fill),
    .act       (act)
  );

  // result stage; ring bytes come from the memories' read registers
  logic              res_line_valid;
  logic              res_from_ring;
  logic [BYTE_W-1:0] res_flow_byte;
  logic              res_host_valid;
  logic [FILL_W-1:0] res_fill;
  logic              res_accepted;
  logic              res_tx_busy;
  logic [BYTE_W-1:0] line_byte;
  logic [BYTE_W-1:0] host_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_line_valid <= act.send_flow || act.tx_get;
      res_from_ring  <= act.tx_get;
      res_flow_byte  <= act.flow_byte;
      res_host_valid <= rx_get;
      res_fill       <= fill_sel[FILL_W-1:0];
      res_accepted   <= rx_put || tx_put;
      res_tx_busy    <= act.tx_busy;
    end
  end

  assign line_byte = res_from_ring ? tx_rdata : res_flow_byte;
  assign host_byte = res_host_valid ? rx_rdata : '0;

  assign m_tdata = {3'b000, res_tx_busy, res_accepted, res_fill, host_byte, res_host_valid,
                    line_byte, res_line_valid};

`ifndef NO_ASSERTIONS
  // a transmit ring read never happens on an empty ring
  assert property (@(posedge clk) disable iff (rst) act.tx_get |-> !tx_empty)
    else $error("transmit ring read while empty");

  // a result reports at most one of line byte and host byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res_line_valid && res_host_valid))
    else $error("line and host byte in the same result");

  // an accepted put reports a nonzero fill unless RING_DEPTH exceeds 512
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_accepted) |-> (res_fill != '0 || RING_DEPTH > 512))
    else $error("accepted put with zero fill");

  // each advance of the input stage loads a result on the next edge
  assert property (@(posedge clk) disable iff (rst) adv |=> m_tvalid)
    else $error("result lost after advance");
`endif

endmodule
